FILE: hdl/illumination_quality_metrics_assert.svh
// ----------------------------------------------------------------------------
// Illumination quality metrics - assertion macros
// Shared wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef ILLUMINATION_QUALITY_METRICS_ASSERT_SVH
`define ILLUMINATION_QUALITY_METRICS_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define IQM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IQM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/iqm_pkg.sv
// ----------------------------------------------------------------------------
// iqm_pkg
// Types, constants and helper functions of the illumination quality metrics.
// ----------------------------------------------------------------------------
package iqm_pkg;

   // port widths
   localparam int IQM_REQ_W      = 24;   // illuminance 16, duty 8
   localparam int IQM_RSP_W      = 144;  // power 16, energy 48, vis 16, flk 32, count 32
   localparam int IQM_CSR_IDX_W  = 2;
   localparam int IQM_CSR_DATA_W = 16;

   // register indexes
   typedef enum logic [IQM_CSR_IDX_W-1:0] {
      CSR_FULL_POWER    = 2'd0,
      CSR_MAX_DUTY      = 2'd1,
      CSR_SAMPLE_RATE   = 2'd2,
      CSR_LOWER_BOUND   = 2'd3
   } iqm_csr_type;

   // register reset values
   localparam logic [15:0] NOM_PWR_RST  = 16'd1000;
   localparam logic [7:0]  MAX_DUTY_RST = 8'd255;
   localparam logic [13:0] SMP_RATE_RST = 14'd100;
   localparam logic [15:0] LOW_BND_RST  = 16'd1280;  // 20.0 lux

   // sequencer states: one per serial operation, plus idle and result
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_PWR,   // full-drive power * duty
      ST_DIV_PWR,   // / max_duty
      ST_DIV_NRG,   // (power << 16) / sample_rate
      ST_MUL_VIS,   // visibility mean * (n-1)
      ST_DIV_VIS,   // / n
      ST_MUL_TRM,   // (|a|+|b|) * sample_rate, or zero without a reversal
      ST_MUL_FLK,   // flicker mean * (n-1)
      ST_DIV_FLK,   // / n
      ST_OUT
   } iqm_state_type;

   // step counts, one bit per step
   localparam logic [5:0] STEPS_MUL_PWR = 6'd8;
   localparam logic [5:0] STEPS_DIV_PWR = 6'd24;
   localparam logic [5:0] STEPS_DIV_NRG = 6'd32;
   localparam logic [5:0] STEPS_MUL_VIS = 6'd32;
   localparam logic [5:0] STEPS_DIV_VIS = 6'd16;
   localparam logic [5:0] STEPS_MUL_TRM = 6'd14;
   localparam logic [5:0] STEPS_MUL_FLK = 6'd32;
   localparam logic [5:0] STEPS_DIV_FLK = 6'd32;

   // last step of an operation state
   function automatic logic [5:0] iqm_last_step(iqm_state_type st);
      logic [5:0] last;
      case (st)
         ST_MUL_PWR: last = STEPS_MUL_PWR;
         ST_DIV_PWR: last = STEPS_DIV_PWR;
         ST_DIV_NRG: last = STEPS_DIV_NRG;
         ST_MUL_VIS: last = STEPS_MUL_VIS;
         ST_DIV_VIS: last = STEPS_DIV_VIS;
         ST_MUL_TRM: last = STEPS_MUL_TRM;
         ST_MUL_FLK: last = STEPS_MUL_FLK;
         ST_DIV_FLK: last = STEPS_DIV_FLK;
         default:    last = 6'd0;
      endcase
      return last;
   endfunction

   // operation that follows
   function automatic iqm_state_type iqm_next_op(iqm_state_type st);
      iqm_state_type nxt;
      case (st)
         ST_MUL_PWR: nxt = ST_DIV_PWR;
         ST_DIV_PWR: nxt = ST_DIV_NRG;
         ST_DIV_NRG: nxt = ST_MUL_VIS;
         ST_MUL_VIS: nxt = ST_DIV_VIS;
         ST_DIV_VIS: nxt = ST_MUL_TRM;
         ST_MUL_TRM: nxt = ST_MUL_FLK;
         ST_MUL_FLK: nxt = ST_DIV_FLK;
         ST_DIV_FLK: nxt = ST_OUT;
         default:    nxt = ST_IDLE;
      endcase
      return nxt;
   endfunction

   // true for states that step the shift-add multiplier
   function automatic logic iqm_is_mul(iqm_state_type st);
      return (st == ST_MUL_PWR) || (st == ST_MUL_VIS) ||
             (st == ST_MUL_TRM) || (st == ST_MUL_FLK);
   endfunction

endpackage

FILE: hdl/illumination_quality_metrics.sv
// ----------------------------------------------------------------------------
// illumination_quality_metrics
// Per-sample power, energy, visibility and flicker metrics of one luminaire.
//
// Usage: a sample word (illuminance, duty) enters on req_; one result word
// (power, energy, visibility mean, flicker mean, sample count) leaves on rsp_
// for every sample. Registers are written on csr_ while no sample is in work.
// The sample is worked by a sequencer over one shift-add multiplier and one
// restoring divider, each handling one bit per cycle; eight operations of
// 8 to 32 steps plus a load cycle each run in turn, and the result state
// then loads the output register and raises rsp_tvalid. No new sample is
// taken before that: req_tready is high only while the sequencer idles.
// The result sits in an output register; a stalled receiver holds the word
// there and the sequencer waits in its result state until the register
// frees. Synchronous reset restores the register defaults, clears history,
// means, energy and count, and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module illumination_quality_metrics (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [iqm_pkg::IQM_REQ_W-1:0]      req_tdata,  // illuminance[15:0], duty[23:16]
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [iqm_pkg::IQM_RSP_W-1:0]      rsp_tdata,  // power[15:0], energy[63:16],
                                                          // visibility_error[79:64],
                                                          // flicker_error[111:80],
                                                          // sample_count[143:112]
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [iqm_pkg::IQM_CSR_IDX_W-1:0]  csr_index,
   input  logic [iqm_pkg::IQM_CSR_DATA_W-1:0] csr_data
);
   import iqm_pkg::*;

   // sequencer
   iqm_state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;

   // registers
   logic [15:0] nom_pwr_ff, nom_pwr_in;
   logic [7:0]  max_duty_ff, max_duty_in;
   logic [13:0] smp_rate_ff, smp_rate_in;
   logic [15:0] low_bnd_ff, low_bnd_in;

   // sample and history
   logic [15:0] illum_ff, illum_in;
   logic [7:0]  duty_ff, duty_in;
   logic [15:0] prev_ff, prev_in;
   logic [15:0] prev2_ff, prev2_in;

   // running state
   logic [31:0] count_ff, count_in;
   logic [47:0] energy_ff, energy_in;
   logic [15:0] vis_mean_ff, vis_mean_in;
   logic [31:0] flk_mean_ff, flk_mean_in;
   logic [15:0] power_ff, power_in;
   logic [29:0] term_ff, term_in;

   // shift-add multiplier
   logic [63:0] mul_acc_ff, mul_acc_in;
   logic [63:0] mul_mcand_ff, mul_mcand_in;
   logic [31:0] mul_mplr_ff, mul_mplr_in;

   // restoring divider
   logic [31:0] div_rem_ff, div_rem_in;
   logic [31:0] div_quo_ff, div_quo_in;
   logic [31:0] div_dsr_ff, div_dsr_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IQM_RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath terms
   logic [63:0] mul_sum;
   logic [32:0] div_trial;
   logic [32:0] div_diff;
   logic        div_ge;
   logic [31:0] n_minus_1;
   logic [7:0]  duty_div;
   logic [13:0] rate_div;
   logic [15:0] power_sat;
   logic [48:0] energy_sum;
   logic [15:0] shortfall;
   logic [15:0] abs_a;
   logic [15:0] abs_b;
   logic [16:0] abs_sum;
   logic        reversal;
   logic [48:0] vis_dividend;
   logic [63:0] flk_dividend;
   logic        last_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one multiplier step: add shifted multiplicand when multiplier bit set
   assign mul_sum = mul_acc_ff + (mul_mplr_ff[0] ? mul_mcand_ff : 64'd0);

   // one divider step: shift in next dividend bit, subtract if it fits
   assign div_trial = {div_rem_ff, div_quo_ff[31]};
   assign div_diff  = div_trial - {1'b0, div_dsr_ff};
   assign div_ge    = (div_trial >= {1'b0, div_dsr_ff});

   // operands and glue
   assign n_minus_1  = count_ff - 32'd1;
   assign duty_div   = (max_duty_ff == 8'd0) ? 8'd1 : max_duty_ff;
   assign rate_div   = (smp_rate_ff == 14'd0) ? 14'd1 : smp_rate_ff;
   assign power_sat  = (div_quo_ff[23:16] != 8'd0) ? 16'hFFFF : div_quo_ff[15:0];
   assign energy_sum = {1'b0, energy_ff} + {17'd0, div_quo_ff};
   assign shortfall  = (low_bnd_ff > illum_ff) ? (low_bnd_ff - illum_ff) : 16'd0;
   assign abs_a      = (illum_ff > prev_ff) ? (illum_ff - prev_ff) : (prev_ff - illum_ff);
   assign abs_b      = (prev_ff > prev2_ff) ? (prev_ff - prev2_ff) : (prev2_ff - prev_ff);
   assign abs_sum    = {1'b0, abs_a} + {1'b0, abs_b};
   assign reversal   = ((illum_ff > prev_ff) && (prev_ff < prev2_ff)) ||
                       ((illum_ff < prev_ff) && (prev_ff > prev2_ff));
   assign vis_dividend = {1'b0, mul_acc_ff[47:0]} + {33'd0, shortfall};
   assign flk_dividend = mul_acc_ff + {34'd0, term_ff};
   assign last_step    = (cnt_ff == iqm_last_step(state_ff));

   // register writes
   always_comb begin
      nom_pwr_in  = nom_pwr_ff;
      max_duty_in = max_duty_ff;
      smp_rate_in = smp_rate_ff;
      low_bnd_in  = low_bnd_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FULL_POWER:    nom_pwr_in  = csr_data;
            CSR_MAX_DUTY:      max_duty_in = csr_data[7:0];
            CSR_SAMPLE_RATE:   smp_rate_in = csr_data[13:0];
            CSR_LOWER_BOUND:   low_bnd_in  = csr_data;
            default:           nom_pwr_in  = nom_pwr_ff;
         endcase
      end
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      illum_in     = illum_ff;
      duty_in      = duty_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      count_in     = count_ff;
      energy_in    = energy_ff;
      vis_mean_in  = vis_mean_ff;
      flk_mean_in  = flk_mean_ff;
      power_in     = power_ff;
      term_in      = term_ff;
      mul_acc_in   = mul_acc_ff;
      mul_mcand_in = mul_mcand_ff;
      mul_mplr_in  = mul_mplr_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dsr_in   = div_dsr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               illum_in = req_tdata[15:0];
               duty_in  = req_tdata[23:16];
               if (count_ff != 32'hFFFF_FFFF) begin
                  count_in = count_ff + 32'd1;
               end
               state_in = ST_MUL_PWR;
               cnt_in   = 6'd0;
            end
         end

         ST_OUT: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_tready) begin
               flk_mean_in  = div_quo_ff;
               prev2_in     = prev_ff;
               prev_in      = illum_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ff, div_quo_ff, vis_mean_ff, energy_ff, power_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            // operation states: load cycle, then one bit per step
            if (last_step) begin
               state_in = iqm_next_op(state_ff);
               cnt_in   = 6'd0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end

            if (cnt_ff != 6'd0) begin
               if (iqm_is_mul(state_ff)) begin
                  mul_acc_in   = mul_sum;
                  mul_mcand_in = {mul_mcand_ff[62:0], 1'b0};
                  mul_mplr_in  = {1'b0, mul_mplr_ff[31:1]};
               end else begin
                  div_rem_in = div_ge ? div_diff[31:0] : div_trial[31:0];
                  div_quo_in = {div_quo_ff[30:0], div_ge};
               end
            end else begin
               case (state_ff)
                  ST_MUL_PWR: begin
                     mul_acc_in   = 64'd0;
                     mul_mcand_in = {48'd0, nom_pwr_ff};
                     mul_mplr_in  = {24'd0, duty_ff};
                  end
                  ST_DIV_PWR: begin
                     div_rem_in = 32'd0;
                     div_quo_in = {mul_acc_ff[23:0], 8'd0};
                     div_dsr_in = {24'd0, duty_div};
                  end
                  ST_DIV_NRG: begin
                     power_in   = power_sat;
                     div_rem_in = 32'd0;
                     div_quo_in = {power_sat, 16'd0};
                     div_dsr_in = {18'd0, rate_div};
                  end
                  ST_MUL_VIS: begin
                     energy_in    = energy_sum[48] ? 48'hFFFF_FFFF_FFFF : energy_sum[47:0];
                     mul_acc_in   = 64'd0;
                     mul_mcand_in = {48'd0, vis_mean_ff};
                     mul_mplr_in  = n_minus_1;
                  end
                  ST_DIV_VIS: begin
                     // dividend < n * 2^16, so its upper part is below n
                     div_rem_in = vis_dividend[47:16];
                     div_quo_in = {vis_dividend[15:0], 16'd0};
                     div_dsr_in = count_ff;
                  end
                  ST_MUL_TRM: begin
                     vis_mean_in  = div_quo_ff[15:0];
                     mul_acc_in   = 64'd0;
                     mul_mcand_in = reversal ? {47'd0, abs_sum} : 64'd0;
                     mul_mplr_in  = {18'd0, smp_rate_ff};
                  end
                  ST_MUL_FLK: begin
                     term_in      = mul_acc_ff[30:1];
                     mul_acc_in   = 64'd0;
                     mul_mcand_in = {32'd0, flk_mean_ff};
                     mul_mplr_in  = n_minus_1;
                  end
                  ST_DIV_FLK: begin
                     // dividend < n * 2^32, so its upper word is below n
                     div_rem_in = flk_dividend[63:32];
                     div_quo_in = flk_dividend[31:0];
                     div_dsr_in = count_ff;
                  end
                  default: begin
                     cnt_in = 6'd0;
                  end
               endcase
            end
         end
      endcase
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 6'd0;
         nom_pwr_ff   <= NOM_PWR_RST;
         max_duty_ff  <= MAX_DUTY_RST;
         smp_rate_ff  <= SMP_RATE_RST;
         low_bnd_ff   <= LOW_BND_RST;
         prev_ff      <= 16'd0;
         prev2_ff     <= 16'd0;
         count_ff     <= 32'd0;
         energy_ff    <= 48'd0;
         vis_mean_ff  <= 16'd0;
         flk_mean_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         nom_pwr_ff   <= nom_pwr_in;
         max_duty_ff  <= max_duty_in;
         smp_rate_ff  <= smp_rate_in;
         low_bnd_ff   <= low_bnd_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         count_ff     <= count_in;
         energy_ff    <= energy_in;
         vis_mean_ff  <= vis_mean_in;
         flk_mean_ff  <= flk_mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      illum_ff     <= illum_in;
      duty_ff      <= duty_in;
      power_ff     <= power_in;
      term_ff      <= term_in;
      mul_acc_ff   <= mul_acc_in;
      mul_mcand_ff <= mul_mcand_in;
      mul_mplr_ff  <= mul_mplr_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_dsr_ff   <= div_dsr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // checks
`include "illumination_quality_metrics_assert.svh"

   `IQM_ASSERT_NEXT(a_start_seq, req_tvalid && req_tready, (state_ff == ST_MUL_PWR) && (cnt_ff == 6'd0), "accepted sample did not start the sequencer")
   `IQM_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "result word appeared outside the result state")
   `IQM_ASSERT_IMPL(a_div_rem_lt, ((state_ff == ST_DIV_PWR) || (state_ff == ST_DIV_NRG) || (state_ff == ST_DIV_VIS) || (state_ff == ST_DIV_FLK)) && (cnt_ff != 6'd0), div_rem_ff < div_dsr_ff, "divider remainder not below divisor")

endmodule
